/* sv/assert_macros.svh */
// Assertion macros shared by the park brake motor controller RTL.
// No dependencies; the macros compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define PBMC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: condition does not hold");

// Consequent must hold in the cycle after the antecedent.
`define PBMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define PBMC_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define PBMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* sv/pbmc_pkg.sv */
// Package for the park brake motor controller: payload types, codes,
// constants and the status code table. No dependencies.
package pbmc_pkg;

  localparam int HISTORY_DEPTH = 6;
  localparam int CUR_W         = 12;
  localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W         = $clog2(HISTORY_DEPTH * (1 << CUR_W));

  localparam int FRAME_ID_W = 11;
  localparam int TIMEOUT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ID = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = CFG_IDX_W'(1);

  localparam logic [FRAME_ID_W-1:0] FRAME_ID_RST = 11'h400;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 16'd2500;
  localparam logic [CUR_W-1:0]      LOCK_LIMIT_RST   = 12'd704;
  localparam logic [CUR_W-1:0]      UNLOCK_LIMIT_RST = 12'd1200;

  // command frame codes in the first data word
  localparam logic [31:0] CODE_LOCK        = 32'h05;
  localparam logic [31:0] CODE_UNLOCK      = 32'h0A;
  localparam logic [31:0] CODE_RESET       = 32'h66;
  localparam logic [31:0] CODE_PROG_UNLOCK = 32'h77;
  localparam logic [31:0] CODE_PROG_LOCK   = 32'h88;

  // button event patterns
  localparam logic [1:0] BTN_LOCK   = 2'b01;
  localparam logic [1:0] BTN_UNLOCK = 2'b10;
  localparam logic [1:0] BTN_BOTH   = 2'b11;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_FRAME  = 2'd1,
    CMD_BUTTON = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_STOPPED  = 2'd0,
    ST_RESET    = 2'd1,
    ST_LOCKED   = 2'd2,
    ST_UNLOCKED = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [CUR_W-1:0]      lock_current;
    logic [CUR_W-1:0]      unlock_current;
    logic [FRAME_ID_W-1:0] frame_id;
    logic [31:0]           frame_word_a;
    logic [31:0]           frame_word_b;
    logic [1:0]            buttons;
  } in_item_t;

  typedef struct packed {
    logic        frame_valid;
    logic [31:0] frame_low_word;
    logic [31:0] frame_high_word;
    logic        lock_drive;
    logic        unlock_drive;
    logic        bridge_enable;
    logic [1:0]  brake_status;
  } out_item_t;

  // moving average comparison results
  typedef struct packed {
    logic lock_over;
    logic unlock_over;
  } hist_flags_t;

  function automatic logic [7:0] status_code(status_t st);
    logic [7:0] code;
    unique case (st)
      ST_STOPPED:  code = 8'h00;
      ST_RESET:    code = 8'h66;
      ST_LOCKED:   code = 8'h05;
      ST_UNLOCKED: code = 8'h0A;
      default:     code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

/* sv/pbmc_history.sv */
// Current histories with running sums and the average-over-limit compare.
// Depends on pbmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pbmc_history (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       sample_fire,
  input  logic [pbmc_pkg::CUR_W-1:0] lock_current,
  input  logic [pbmc_pkg::CUR_W-1:0] unlock_current,
  input  logic [pbmc_pkg::CUR_W-1:0] lock_limit,
  input  logic [pbmc_pkg::CUR_W-1:0] unlock_limit,
  output pbmc_pkg::hist_flags_t      flags
);

  localparam int D     = pbmc_pkg::HISTORY_DEPTH;
  localparam int SW    = pbmc_pkg::SUM_W;
  localparam int SLOTW = pbmc_pkg::SLOT_W;

  logic [pbmc_pkg::CUR_W-1:0] lock_hist_r   [D];
  logic [pbmc_pkg::CUR_W-1:0] unlock_hist_r [D];
  logic [SLOTW-1:0]           slot_r, slot_nxt;
  logic [SW-1:0]              lock_sum_r, lock_sum_nxt;
  logic [SW-1:0]              unlock_sum_r, unlock_sum_nxt;
  logic [SW-1:0]              lock_thr, unlock_thr;

  // sum/D > L  <=>  sum > L*D + D-1
  assign lock_thr   = SW'(lock_limit) * SW'(D) + SW'(D - 1);
  assign unlock_thr = SW'(unlock_limit) * SW'(D) + SW'(D - 1);

  assign lock_sum_nxt   = lock_sum_r - SW'(lock_hist_r[slot_r]) + SW'(lock_current);
  assign unlock_sum_nxt = unlock_sum_r - SW'(unlock_hist_r[slot_r]) + SW'(unlock_current);
  assign slot_nxt = (slot_r == SLOTW'(D - 1)) ? '0 : slot_r + SLOTW'(1);

  assign flags.lock_over   = lock_sum_nxt > lock_thr;
  assign flags.unlock_over = unlock_sum_nxt > unlock_thr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) begin
        lock_hist_r[i]   <= '0;
        unlock_hist_r[i] <= '0;
      end
      slot_r       <= '0;
      lock_sum_r   <= '0;
      unlock_sum_r <= '0;
    end else if (sample_fire) begin
      lock_hist_r[slot_r]   <= lock_current;
      unlock_hist_r[slot_r] <= unlock_current;
      slot_r       <= slot_nxt;
      lock_sum_r   <= lock_sum_nxt;
      unlock_sum_r <= unlock_sum_nxt;
    end
  end

  `PBMC_ASSERT_ALWAYS(a_slot_range, clk, rst_n, slot_r <= SLOTW'(D - 1))
  `PBMC_ASSERT_ALWAYS(a_lock_sum_max, clk, rst_n, lock_sum_r <= SW'(D * 4095))
  `PBMC_ASSERT_ALWAYS(a_unlock_sum_max, clk, rst_n, unlock_sum_r <= SW'(D * 4095))

endmodule

/* sv/pbmc_ctrl.sv */
// Command handling, unlock timeout, drive/status state and result build.
// Depends on pbmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pbmc_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  pbmc_pkg::in_item_t              item,
  input  logic [pbmc_pkg::FRAME_ID_W-1:0] frame_id_cfg,
  input  logic [pbmc_pkg::TIMEOUT_W-1:0]  timeout_cfg,
  input  pbmc_pkg::hist_flags_t           flags,
  output logic [pbmc_pkg::CUR_W-1:0]      lock_limit,
  output logic [pbmc_pkg::CUR_W-1:0]      unlock_limit,
  output pbmc_pkg::out_item_t             result
);

  pbmc_pkg::status_t status_r, status_nxt;
  logic lock_on_r, lock_on_nxt;
  logic unlock_on_r, unlock_on_nxt;
  logic enable_on_r, enable_on_nxt;
  logic armed_r, armed_nxt;
  logic [pbmc_pkg::TIMEOUT_W-1:0] elapsed_r, elapsed_nxt;
  logic [3:0] alive_r, alive_nxt;
  logic [pbmc_pkg::CUR_W-1:0] lock_limit_r, lock_limit_nxt;
  logic [pbmc_pkg::CUR_W-1:0] unlock_limit_r, unlock_limit_nxt;

  assign lock_limit   = lock_limit_r;
  assign unlock_limit = unlock_limit_r;

  always_comb begin
    logic [31:0] code;
    logic [pbmc_pkg::TIMEOUT_W-1:0] tick_cnt;
    logic [pbmc_pkg::CUR_W-1:0] limit_sel;

    status_nxt       = status_r;
    lock_on_nxt      = lock_on_r;
    unlock_on_nxt    = unlock_on_r;
    enable_on_nxt    = enable_on_r;
    armed_nxt        = armed_r;
    elapsed_nxt      = elapsed_r;
    alive_nxt        = alive_r;
    lock_limit_nxt   = lock_limit_r;
    unlock_limit_nxt = unlock_limit_r;
    code             = (item.frame_id == frame_id_cfg) ? item.frame_word_a : '0;
    tick_cnt         = elapsed_r + pbmc_pkg::TIMEOUT_W'(1);
    limit_sel        = '0;
    result           = '0;

    case (pbmc_pkg::cmd_t'(item.cmd))
      pbmc_pkg::CMD_FRAME: begin
        armed_nxt = 1'b0;
        if (code == pbmc_pkg::CODE_UNLOCK) begin
          lock_on_nxt   = 1'b0;
          unlock_on_nxt = 1'b1;
          armed_nxt     = 1'b1;
          elapsed_nxt   = '0;
        end else if (code == pbmc_pkg::CODE_LOCK) begin
          unlock_on_nxt = 1'b0;
          lock_on_nxt   = 1'b1;
        end else if (code == pbmc_pkg::CODE_RESET ||
                     code == pbmc_pkg::CODE_PROG_UNLOCK ||
                     code == pbmc_pkg::CODE_PROG_LOCK) begin
          if (code == pbmc_pkg::CODE_PROG_UNLOCK) begin
            unlock_limit_nxt = item.frame_word_b[pbmc_pkg::CUR_W-1:0];
          end
          if (code == pbmc_pkg::CODE_PROG_LOCK) begin
            lock_limit_nxt = item.frame_word_b[pbmc_pkg::CUR_W-1:0];
          end
          status_nxt    = pbmc_pkg::ST_RESET;
          lock_on_nxt   = 1'b0;
          unlock_on_nxt = 1'b0;
          enable_on_nxt = 1'b1;
        end else begin
          status_nxt    = pbmc_pkg::ST_STOPPED;
          lock_on_nxt   = 1'b0;
          unlock_on_nxt = 1'b0;
        end
      end
      pbmc_pkg::CMD_BUTTON: begin
        armed_nxt = 1'b0;
        case (item.buttons)
          pbmc_pkg::BTN_LOCK: begin
            unlock_on_nxt = 1'b0;
            lock_on_nxt   = 1'b1;
          end
          pbmc_pkg::BTN_UNLOCK: begin
            lock_on_nxt   = 1'b0;
            unlock_on_nxt = 1'b1;
            armed_nxt     = 1'b1;
            elapsed_nxt   = '0;
          end
          pbmc_pkg::BTN_BOTH: begin
            status_nxt    = pbmc_pkg::ST_STOPPED;
            enable_on_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      pbmc_pkg::CMD_TICK: begin
        if (armed_r) begin
          elapsed_nxt = tick_cnt;
          if (tick_cnt >= timeout_cfg) begin
            status_nxt    = pbmc_pkg::ST_UNLOCKED;
            lock_on_nxt   = 1'b0;
            unlock_on_nxt = 1'b0;
            armed_nxt     = 1'b0;
          end
        end
      end
      default: begin
        // current sample pair; unlock over-limit wins on status
        if (flags.lock_over) begin
          status_nxt  = pbmc_pkg::ST_LOCKED;
          lock_on_nxt = 1'b0;
        end
        if (flags.unlock_over) begin
          status_nxt    = pbmc_pkg::ST_UNLOCKED;
          unlock_on_nxt = 1'b0;
        end
        alive_nxt = alive_r + 4'd1;
        if (status_nxt == pbmc_pkg::ST_UNLOCKED) begin
          limit_sel = unlock_limit_r;
        end else if (status_nxt == pbmc_pkg::ST_LOCKED) begin
          limit_sel = lock_limit_r;
        end
        result.frame_valid     = 1'b1;
        result.frame_low_word  = {4'd0, item.unlock_current, 4'd0, item.lock_current};
        result.frame_high_word = {4'd0, limit_sel, pbmc_pkg::status_code(status_nxt),
                                  2'd0, unlock_on_nxt, lock_on_nxt, alive_nxt};
      end
    endcase

    result.lock_drive    = lock_on_nxt;
    result.unlock_drive  = unlock_on_nxt;
    result.bridge_enable = enable_on_nxt;
    result.brake_status  = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r       <= pbmc_pkg::ST_STOPPED;
      lock_on_r      <= 1'b0;
      unlock_on_r    <= 1'b0;
      enable_on_r    <= 1'b1;
      armed_r        <= 1'b0;
      elapsed_r      <= '0;
      alive_r        <= '0;
      lock_limit_r   <= pbmc_pkg::LOCK_LIMIT_RST;
      unlock_limit_r <= pbmc_pkg::UNLOCK_LIMIT_RST;
    end else if (fire) begin
      status_r       <= status_nxt;
      lock_on_r      <= lock_on_nxt;
      unlock_on_r    <= unlock_on_nxt;
      enable_on_r    <= enable_on_nxt;
      armed_r        <= armed_nxt;
      elapsed_r      <= elapsed_nxt;
      alive_r        <= alive_nxt;
      lock_limit_r   <= lock_limit_nxt;
      unlock_limit_r <= unlock_limit_nxt;
    end
  end

  // the two bridge directions are never commanded together
  `PBMC_ASSERT_ALWAYS(a_drives_exclusive, clk, rst_n, !(lock_on_r && unlock_on_r))
  // the timeout only runs after an unlock request, which drops the lock drive
  `PBMC_ASSERT_ALWAYS(a_armed_no_lock, clk, rst_n, !(armed_r && lock_on_r))
  // alive counter moves only with a fired sample
  `PBMC_ASSERT_NEXT(a_alive_hold, clk, rst_n, !fire, $stable(alive_r))

endmodule

/* sv/park_brake_motor_controller.sv */
// Park brake motor controller: an accepted input passes the input register, then
// the result register; throughput one transaction per cycle unless out_stall
// holds the result. The state update between the two registers is combinational,
// which sets that rate; the average uses running sums so no summation loop is in
// the path. Reset (rst_n, synchronous, active low) clears histories, drives off,
// bridge enabled, limits 704/1200, frame id 0x400, timeout 2500.
`include "assert_macros.svh"

module park_brake_motor_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  // input transactions
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pbmc_pkg::in_item_t              in_item,
  // result transactions
  output logic                            out_valid,
  input  logic                            out_stall,
  output pbmc_pkg::out_item_t             out_item,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pbmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbmc_pkg::CFG_DATA_W-1:0] cfg_data
);

  // input register: holds an accepted transaction until the compute stage fires
  logic               in_valid_r, in_valid_nxt;
  pbmc_pkg::in_item_t in_item_r;

  // result register: parts the compute stage from a stalled consumer
  logic                out_valid_r, out_valid_nxt;
  pbmc_pkg::out_item_t out_item_r;
  pbmc_pkg::out_item_t result;

  // configuration registers
  logic [pbmc_pkg::FRAME_ID_W-1:0] frame_id_cfg_r;
  logic [pbmc_pkg::TIMEOUT_W-1:0]  timeout_cfg_r;

  logic                       advance;
  logic                       in_take;
  logic                       sample_fire;
  logic [pbmc_pkg::CUR_W-1:0] lock_limit;
  logic [pbmc_pkg::CUR_W-1:0] unlock_limit;
  pbmc_pkg::hist_flags_t      flags;

  // compute stage fires when it holds a transaction and the result slot is
  // free or being drained this cycle
  assign advance     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall    = in_valid_r && !advance;
  assign in_take     = in_valid && !in_stall;
  assign sample_fire = advance && (pbmc_pkg::cmd_t'(in_item_r.cmd) == pbmc_pkg::CMD_SAMPLE);

  assign in_valid_nxt  = in_take || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_id_cfg_r <= pbmc_pkg::FRAME_ID_RST;
      timeout_cfg_r  <= pbmc_pkg::TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pbmc_pkg::CFG_FRAME_ID: frame_id_cfg_r <= cfg_data[pbmc_pkg::FRAME_ID_W-1:0];
        pbmc_pkg::CFG_TIMEOUT:  timeout_cfg_r  <= cfg_data[pbmc_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  pbmc_history u_history (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_fire    (sample_fire),
    .lock_current   (in_item_r.lock_current),
    .unlock_current (in_item_r.unlock_current),
    .lock_limit     (lock_limit),
    .unlock_limit   (unlock_limit),
    .flags          (flags)
  );

  pbmc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (advance),
    .item         (in_item_r),
    .frame_id_cfg (frame_id_cfg_r),
    .timeout_cfg  (timeout_cfg_r),
    .flags        (flags),
    .lock_limit   (lock_limit),
    .unlock_limit (unlock_limit),
    .result       (result)
  );

  // a fired transaction always lands in the result register
  `PBMC_ASSERT_NEXT(a_fire_lands, clk, rst_n, advance, out_valid_r)
  // a held transaction that cannot fire must backpressure the producer
  `PBMC_ASSERT_ALWAYS(a_hold_stalls, clk, rst_n, !(in_valid_r && !advance) || in_stall)
  // a waiting result that is not taken stays valid
  `PBMC_ASSERT_NEXT(a_result_kept, clk, rst_n, out_valid_r && out_stall, out_valid_r)

endmodule
